// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; NO_ASSERTIONS compiles them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ----- rtl/core/iirlp_pkg.sv -----
// ----------------------------------------------------------------------------
// iirlp_pkg
// Widths and fixed Q3.28 coefficients of the fifth-order low-pass filter.
// ----------------------------------------------------------------------------
package iirlp_pkg;

  localparam int ORDER     = 5;
  localparam int SAMPLE_W  = 16;
  localparam int COEF_FRAC = 28;
  localparam int HIST_FRAC = 8;
  localparam int HIST_W    = SAMPLE_W + HIST_FRAC;
  localparam int COEF_W    = 31;
  localparam int ACC_W     = 58;
  localparam int YW_W      = ACC_W - COEF_FRAC;

  localparam int OP_FILTER = 0;
  localparam int OP_CLEAR  = 1;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [HIST_W-1:0] hist_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // feed-forward b0..b5
  localparam coef_t COEF_B [ORDER+1] = '{
    31'sd1861116, 31'sd9305578, 31'sd18611157,
    31'sd18611157, 31'sd9305578, 31'sd1861116
  };

  // feedback a1..a5
  localparam coef_t COEF_A [ORDER] = '{
    -31'sd530402051, 31'sd540487550, -31'sd295981760,
    31'sd87944377, -31'sd10927870
  };

  typedef struct packed {
    logic en;
    logic clr;
  } cell_ctrl_t;

endpackage

// ----- rtl/core/iirlp_in_if.sv -----
// ----------------------------------------------------------------------------
// iirlp_in_if
// Input channel: op code and raw sample with valid/ready.
// ----------------------------------------------------------------------------
interface iirlp_in_if;
  import iirlp_pkg::*;

  logic    valid;
  logic    ready;
  logic    op;
  sample_t sample;

  modport source (output valid, output op, output sample, input ready);
  modport sink   (input valid, input op, input sample, output ready);
endinterface

// ----- rtl/core/iirlp_out_if.sv -----
// ----------------------------------------------------------------------------
// iirlp_out_if
// Output channel: filtered sample with valid/ready.
// ----------------------------------------------------------------------------
interface iirlp_out_if;
  import iirlp_pkg::*;

  logic    valid;
  logic    ready;
  sample_t filtered;

  modport source (output valid, output filtered, input ready);
  modport sink   (input valid, input filtered, output ready);
endinterface

// ----- rtl/core/iirlp_cell.sv -----
// ----------------------------------------------------------------------------
// iirlp_cell
// One transposed-form delay cell: when enabled, s <= b*x - a*y + s from the next cell, or zero on clear.
// ----------------------------------------------------------------------------
module iirlp_cell #(
  parameter iirlp_pkg::coef_t A = '0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  iirlp_pkg::cell_ctrl_t ctrl_i,
  input  iirlp_pkg::acc_t       bx_i,
  input  iirlp_pkg::hist_t      y_i,
  input  iirlp_pkg::acc_t       s_next_i,
  output iirlp_pkg::acc_t       s_o
);
  import iirlp_pkg::*;

  logic signed [COEF_W+HIST_W-1:0] ay;
  acc_t s_d, s_q;

  assign ay = A * y_i;

  always_comb begin
    s_d = s_q;
    if (ctrl_i.en) begin
      if (ctrl_i.clr) begin
        s_d = '0;
      end else begin
        s_d = bx_i - ACC_W'(ay) + s_next_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q <= '0;
    end else begin
      s_q <= s_d;
    end
  end

  assign s_o = s_q;
endmodule

// ----- rtl/core/iir_lowpass_fifth_order.sv -----
// ----------------------------------------------------------------------------
// iir_lowpass_fifth_order
// Fifth-order Butterworth low-pass, fixed point, transposed delay chain.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries op and sample; op filter yields one filtered sample on
//   out_ch, op clear zeroes the filter history and yields nothing.
//   A transfer on either channel happens when valid and ready are high.
// Pipeline: one stage registers the b*x products, one updates the delay
//   cells and loads the output register.
// Throughput: one item per cycle while out_ch takes results. The new
//   output feeds the a*y terms of all five cells in the same cycle, so
//   the recursion closes in one register step.
// Reset: all delay cells clear to zero, both pipeline slots empty.
// Stall: a held result keeps filter cell updates waiting, not clears; the
//   product stage holds one filter op, and in_ch.ready drops till out_ch moves.
// ----------------------------------------------------------------------------
module iir_lowpass_fifth_order (
  input logic         clk_i,
  input logic         rst_ni,
  iirlp_in_if.sink    in_ch,
  iirlp_out_if.source out_ch
);
  import iirlp_pkg::*;

  logic       s1_valid_q;
  logic       s1_op_q;
  acc_t       bx_q [ORDER+1];
  logic       out_free;
  logic       s1_fire;
  logic       fire_filter;
  logic       in_xfer;
  cell_ctrl_t ctrl;
  acc_t       s [ORDER+1];
  acc_t       acc;
  acc_t       acc_rnd;
  logic signed [YW_W-1:0] y_wide;
  hist_t      y;
  logic signed [HIST_W:0] y_rnd;
  logic signed [SAMPLE_W:0] f_wide;
  sample_t    filt_d;
  sample_t    filt_q;
  logic       out_valid_q;

  assign out_free    = !out_valid_q || out_ch.ready;
  assign s1_fire     = s1_valid_q && (s1_op_q || out_free);
  assign fire_filter = s1_fire && !s1_op_q;
  assign in_ch.ready = !s1_valid_q || s1_fire;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // product stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  for (genvar k = 0; k <= ORDER; k++) begin : g_bx
    logic signed [COEF_W+SAMPLE_W-1:0] prod;
    assign prod = COEF_B[k] * in_ch.sample;
    always_ff @(posedge clk_i) begin
      if (in_xfer) begin
        bx_q[k] <= ACC_W'(prod) <<< HIST_FRAC;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_op_q <= in_ch.op;
    end
  end

  // output of the filter from the head cell
  assign acc     = bx_q[0] + s[0];
  assign acc_rnd = acc + (ACC_W'(1) <<< (COEF_FRAC - 1));
  assign y_wide  = acc_rnd[ACC_W-1:COEF_FRAC];

  always_comb begin
    if (y_wide[YW_W-1:HIST_W-1] == '0 || y_wide[YW_W-1:HIST_W-1] == '1) begin
      y = y_wide[HIST_W-1:0];
    end else if (y_wide[YW_W-1]) begin
      y = {1'b1, {(HIST_W-1){1'b0}}};
    end else begin
      y = {1'b0, {(HIST_W-1){1'b1}}};
    end
  end

  assign y_rnd  = {y[HIST_W-1], y} + (HIST_W+1)'(1 << (HIST_FRAC - 1));
  assign f_wide = y_rnd[HIST_W:HIST_FRAC];

  always_comb begin
    if (f_wide[SAMPLE_W] == f_wide[SAMPLE_W-1]) begin
      filt_d = f_wide[SAMPLE_W-1:0];
    end else if (f_wide[SAMPLE_W]) begin
      filt_d = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      filt_d = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  // delay cells
  assign ctrl.en  = s1_fire;
  assign ctrl.clr = (s1_op_q == 1'(OP_CLEAR));
  assign s[ORDER] = '0;

  for (genvar k = 0; k < ORDER; k++) begin : g_cell
    iirlp_cell #(
      .A (COEF_A[k])
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .bx_i     (bx_q[k+1]),
      .y_i      (y),
      .s_next_i (s[k+1]),
      .s_o      (s[k])
    );
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire_filter) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_filter) begin
      filt_q <= filt_d;
    end
  end

  assign out_ch.valid    = out_valid_q;
  assign out_ch.filtered = filt_q;

`include "assert_macros.svh"

  `ASSERT_CLK(a_clear_zeroes, clk_i, rst_ni, (s1_fire && s1_op_q) |=> (s[0] == '0))
  `ASSERT_CLK(a_filter_gives_out, clk_i, rst_ni, fire_filter |=> out_valid_q)
  `ASSERT_CLK(a_out_source, clk_i, rst_ni, $rose(out_valid_q) |-> $past(fire_filter))
  `ASSERT_NEVER(a_fire_while_full, clk_i, rst_ni, fire_filter && !out_free)

endmodule

// ----- test/tb_iir_lowpass_fifth_order.sv -----
// ----------------------------------------------------------------------------
// tb_iir_lowpass_fifth_order
// Self-checking bench for the fifth-order fixed-point low-pass filter. A
// bit-exact predictor of the direct-form-I recursion (Q16.8 feedback, round
// half up, saturation) runs beside the block. Every filtered output is
// compared with the oldest prediction. Both channels idle at random, and
// one long output stall backs the block up.
// ----------------------------------------------------------------------------
module tb_iir_lowpass_fifth_order;
  timeunit 1ns;
  timeprecision 1ps;

  import iirlp_pkg::*;

  localparam int  CYCLE_LIMIT = 200000;
  localparam int  IDLE_PCT    = 27;
  localparam int  MAX_PRINTS  = 20;
  localparam int  TAPS        = 5;
  localparam int  Y_FRAC      = 8;
  localparam int  K_FRAC      = 28;
  localparam logic OP_FILT = 1'(OP_FILTER);
  localparam logic OP_CLR  = 1'(OP_CLEAR);

  // Q3.28 feed-forward b0..b5 and feedback a1..a5
  localparam longint FF_TAP [TAPS+1] = '{
    64'sd1861116, 64'sd9305578, 64'sd18611157,
    64'sd18611157, 64'sd9305578, 64'sd1861116
  };
  localparam longint FB_TAP [TAPS] = '{
    -64'sd530402051, 64'sd540487550, -64'sd295981760,
    64'sd87944377, -64'sd10927870
  };

  logic clk;
  logic rst_n;

  iirlp_in_if  in_ch ();
  iirlp_out_if out_ch ();

  iir_lowpass_fifth_order u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sample_t x_delay [TAPS];
  hist_t   y_delay [TAPS];
  sample_t expected_filtered [$];
  int      err_count;
  int      cycle_count;
  bit      tx_idle_on;
  bit      rx_idle_on;
  int      rx_hold_req;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.op         <= OP_FILT;
    in_ch.sample     <= '0;
    out_ch.ready     <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_error(input string msg);
    if (err_count < MAX_PRINTS) $display("ERROR @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic longint clip(input longint v, input int width);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (width - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic void clear_history();
    for (int k = 0; k < TAPS; k++) begin
      x_delay[k] = '0;
      y_delay[k] = '0;
    end
  endfunction

  function automatic sample_t predict_filtered(input sample_t x);
    longint acc;
    longint y;
    acc = FF_TAP[0] * longint'(x) * 256;
    for (int k = 0; k < TAPS; k++) begin
      acc += FF_TAP[k+1] * longint'(x_delay[k]) * 256;
      acc -= FB_TAP[k] * longint'(y_delay[k]);
    end
    y = clip((acc + (longint'(1) <<< (K_FRAC - 1))) >>> K_FRAC, HIST_W);
    for (int k = TAPS - 1; k > 0; k--) begin
      x_delay[k] = x_delay[k-1];
      y_delay[k] = y_delay[k-1];
    end
    x_delay[0] = x;
    y_delay[0] = hist_t'(y);
    return sample_t'(clip((y + (longint'(1) <<< (Y_FRAC - 1))) >>> Y_FRAC, SAMPLE_W));
  endfunction

  // called right after a rising edge; returns right after the transfer edge
  task automatic send_item(input logic op, input sample_t smp);
    while (tx_idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.op     <= op;
    in_ch.sample <= smp;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    if (op == OP_CLR) clear_history();
    else expected_filtered.push_back(predict_filtered(smp));
    @(posedge clk);
  endtask

  // output sink: random stalls, plus long holds on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_req > 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= !(rx_idle_on && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // result checker; values sampled mid-cycle, before the transfer edge
  initial begin
    sample_t want;
    forever begin
      @(negedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (expected_filtered.size() == 0) begin
          report_error($sformatf("unexpected result %0d", out_ch.filtered));
        end else begin
          want = expected_filtered.pop_front();
          if (out_ch.filtered !== want)
            report_error($sformatf("filtered %0d, expected %0d", out_ch.filtered, want));
        end
      end
    end
  end

  task automatic test_field_extremes();
    send_item(OP_FILT, 16'sh7fff);
    send_item(OP_FILT, -16'sh8000);
    send_item(OP_FILT, 16'sh0000);
    send_item(OP_FILT, -16'sh0001);
    send_item(OP_FILT, 16'sh0001);
  endtask

  task automatic test_clear_request();
    send_item(OP_CLR, 16'sh8000);
    send_item(OP_FILT, 16'sh0064);
  endtask

  // full-scale step: the overshoot clips the Q16.8 feedback and the output
  task automatic test_step_overshoot();
    send_item(OP_CLR, 16'sh7fff);
    repeat (7) send_item(OP_FILT, -16'sh8000);
    repeat (10) send_item(OP_FILT, 16'sh7fff);
  endtask

  task automatic test_random_stream(input int n_items);
    int      mode;
    int      period;
    int      phase;
    sample_t base;
    sample_t smp;
    mode   = 0;
    period = 8;
    phase  = 0;
    base   = '0;
    for (int i = 0; i < n_items; i++) begin
      if (i % 32 == 0) begin
        mode   = $urandom_range(3);
        period = $urandom_range(40, 4);
        base   = sample_t'($urandom);
      end
      case (mode)
        0: smp = sample_t'($urandom);
        1: smp = base + sample_t'($urandom_range(511)) - 16'sd256;
        2: smp = ((phase / (period / 2)) % 2 == 0) ? 16'sh7fff : -16'sh8000;
        default: smp = base;
      endcase
      phase++;
      if ($urandom_range(99) < 2) send_item(OP_CLR, sample_t'($urandom));
      else send_item(OP_FILT, smp);
    end
  endtask

  task automatic test_output_backpressure();
    tx_idle_on  = 1'b0;
    rx_hold_req = 300;
    test_random_stream(120);
    tx_idle_on  = 1'b1;
  endtask

  task automatic test_full_rate();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random_stream(200);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin
    err_count   = 0;
    cycle_count = 0;
    tx_idle_on  = 1'b1;
    rx_idle_on  = 1'b1;
    rx_hold_req = 0;
    clear_history();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_clear_request();
    test_step_overshoot();
    test_random_stream(700);
    test_output_backpressure();
    test_full_rate();
    test_random_stream(560);

    in_ch.valid <= 1'b0;
    while (expected_filtered.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
